@@ hw/rtl/fcbs_pkg.sv @@
// ----------------------------------------------------------------------------
// fcbs_pkg: shared types and constants
// Formats, memory sizes, operation codes and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fcbs_pkg;

    localparam int MAX_TAPS  = 1024;
    localparam int TAP_AW    = 10;
    localparam int CHANNELS  = 2;
    localparam int CH_W      = 1;
    localparam int MEM_DEPTH = 2048;
    localparam int MEM_AW    = 11;
    localparam int LEN_W     = 11;
    localparam int SMP_W     = 24;
    localparam int FADE_W    = 17;
    localparam int PROD_W    = 48;
    localparam int ACC_W     = 58;
    localparam int SUM_W     = 38;
    localparam int DIFF_W    = 39;
    localparam int PADDR_W   = 2;
    localparam int PDATA_W   = 32;

    localparam logic [FADE_W-1:0] FADE_ONE   = 17'd65536;
    localparam logic [FADE_W-1:0] RESET_STEP = 17'd137;
    localparam logic [LEN_W-1:0]  RESET_LEN  = 11'd257;
    localparam logic [LEN_W-1:0]  LEN_MAX    = 11'd1024;

    localparam logic [2:0] OP_SAMPLE     = 3'd0;
    localparam logic [2:0] OP_TAP_WRITE  = 3'd1;
    localparam logic [2:0] OP_COMMIT     = 3'd2;
    localparam logic [2:0] OP_CLEAR      = 3'd3;
    localparam logic [2:0] OP_COMMIT_NOW = 3'd4;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [PADDR_W-1:0] ADDR_FADE_STEP = 2'd0;

    typedef struct packed {
        logic [2:0]              operation;
        logic [CH_W-1:0]         channel;
        logic signed [SMP_W-1:0] sample_in;
        logic [TAP_AW-1:0]       tap_index;
        logic signed [SMP_W-1:0] tap_value;
        logic [LEN_W-1:0]        tap_length;
    } t_in_word;

    typedef struct packed {
        logic                    result_kind;
        logic signed [SMP_W-1:0] sample_out;
        logic                    accepted;
        logic                    fading_now;
    } t_out_word;

    typedef struct packed {
        logic sweep_init;
        logic sweep_clr;
        logic capture;
        logic tap_wr;
        logic commit;
        logic samp_wr;
        logic mac_run;
        logic pass_b;
        logic save_a;
        logic save_b;
        logic mix1;
        logic mix2;
        logic mix3;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic mac_done;
        logic fading;
        logic out_free;
        logic commit_clr;
    } t_status;

endpackage

`default_nettype wire

@@ hw/rtl/fcbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcbs_ctrl: sequencing controller
// Runs the reset and clear sweeps and walks each word through its tap write, commit or filter phases.
// ----------------------------------------------------------------------------
`default_nettype none

module fcbs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [2:0]       i_op,
    input  wire fcbs_pkg::t_status i_st,
    output logic                  o_in_ready,
    output fcbs_pkg::t_cmd        o_cmd
);

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_TAP    = 4'd2;
    localparam logic [3:0] ST_COMMIT = 4'd3;
    localparam logic [3:0] ST_SWR    = 4'd4;
    localparam logic [3:0] ST_MACA   = 4'd5;
    localparam logic [3:0] ST_MACB   = 4'd6;
    localparam logic [3:0] ST_MIX1   = 4'd7;
    localparam logic [3:0] ST_MIX2   = 4'd8;
    localparam logic [3:0] ST_MIX3   = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;
    localparam logic [3:0] ST_CLR    = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_clr_pend, n_clr_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_clr_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_pend <= n_clr_pend;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_pend = r_clr_pend;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.sweep_init = 1'b1;
                if (i_st.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    unique case (i_op)
                        fcbs_pkg::OP_SAMPLE:     n_state = ST_SWR;
                        fcbs_pkg::OP_TAP_WRITE:  n_state = ST_TAP;
                        fcbs_pkg::OP_COMMIT:     n_state = ST_COMMIT;
                        fcbs_pkg::OP_COMMIT_NOW: n_state = ST_COMMIT;
                        fcbs_pkg::OP_CLEAR:      n_state = ST_CLR;
                        default:                 n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TAP: begin
                o_cmd.tap_wr = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_clr_pend   = i_st.commit_clr;
                n_state      = ST_EMIT;
            end
            ST_SWR: begin
                o_cmd.samp_wr = 1'b1;
                n_state       = ST_MACA;
            end
            ST_MACA: begin
                o_cmd.mac_run = 1'b1;
                if (i_st.mac_done) begin
                    o_cmd.save_a = 1'b1;
                    n_state      = i_st.fading ? ST_MACB : ST_MIX1;
                end
            end
            ST_MACB: begin
                o_cmd.mac_run = 1'b1;
                o_cmd.pass_b  = 1'b1;
                if (i_st.mac_done) begin
                    o_cmd.save_b = 1'b1;
                    n_state      = ST_MIX1;
                end
            end
            ST_MIX1: begin
                o_cmd.mix1 = 1'b1;
                n_state    = ST_MIX2;
            end
            ST_MIX2: begin
                o_cmd.mix2 = 1'b1;
                n_state    = ST_MIX3;
            end
            ST_MIX3: begin
                o_cmd.mix3 = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_clr_pend = 1'b0;
                    n_state    = r_clr_pend ? ST_CLR : ST_IDLE;
                end
            end
            ST_CLR: begin
                o_cmd.sweep_clr = 1'b1;
                if (i_st.sweep_last) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/fcbs_dpath.sv @@
// ----------------------------------------------------------------------------
// fcbs_dpath: filter datapath
// History and coefficient memories, shared MAC, crossfade mixer, bank
// and fade state, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcbs_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fcbs_pkg::t_cmd                i_cmd,
    output fcbs_pkg::t_status                  o_st,
    input  wire fcbs_pkg::t_in_word            i_in,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output fcbs_pkg::t_out_word                o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [fcbs_pkg::FADE_W-1:0]   i_cfg_step,
    output logic [fcbs_pkg::FADE_W-1:0]        o_step
);

    localparam int MIX_W  = 57;
    localparam int TERM_W = 41;
    localparam int Y_W    = 42;
    localparam int PLO_W  = 37;
    localparam logic signed [fcbs_pkg::ACC_W-1:0] ACC_HALF = 58'sd524288;
    localparam logic signed [MIX_W-1:0]           MIX_HALF = 57'sd32768;
    localparam logic signed [Y_W-1:0]             Y_MAX    = 42'sd8388607;
    localparam logic signed [Y_W-1:0]             Y_MIN    = -42'sd8388608;
    localparam logic signed [fcbs_pkg::SMP_W-1:0] TAP_UNIT = 24'sd1048576;

    // captured word
    logic [2:0]                           r_op;
    logic [fcbs_pkg::CH_W-1:0]            r_ch;
    logic signed [fcbs_pkg::SMP_W-1:0]    r_sample;
    logic [fcbs_pkg::TAP_AW-1:0]          r_tap_idx;
    logic signed [fcbs_pkg::SMP_W-1:0]    r_tap_val;
    logic [fcbs_pkg::LEN_W-1:0]           r_tap_len;

    // filter state
    logic [fcbs_pkg::TAP_AW-1:0]          r_wp [fcbs_pkg::CHANNELS];
    logic [fcbs_pkg::LEN_W-1:0]           r_len [2];
    logic                                 r_active;
    logic                                 r_fading;
    logic [fcbs_pkg::FADE_W-1:0]          r_level;
    logic [fcbs_pkg::FADE_W-1:0]          r_step;
    logic [fcbs_pkg::MEM_AW-1:0]          r_sweep;

    // memories
    logic signed [fcbs_pkg::SMP_W-1:0]    dmem [fcbs_pkg::MEM_DEPTH];
    logic signed [fcbs_pkg::SMP_W-1:0]    cmem [fcbs_pkg::MEM_DEPTH];
    logic signed [fcbs_pkg::SMP_W-1:0]    r_dq, r_cq;

    // mac pipeline
    logic [fcbs_pkg::LEN_W-1:0]           r_idx;
    logic                                 r_v1, r_v2;
    logic signed [fcbs_pkg::PROD_W-1:0]   r_prod;
    logic signed [fcbs_pkg::ACC_W-1:0]    r_acc;
    logic signed [fcbs_pkg::SUM_W-1:0]    r_a, r_b;
    logic [PLO_W-1:0]                     r_plo;
    logic signed [PLO_W-1:0]              r_phi;
    fcbs_pkg::t_out_word                  r_res;

    logic [fcbs_pkg::TAP_AW-1:0]          wp_cur, wp_new;
    logic                                 staged, bank_sel, issue, mac_clr, tap_we;
    logic [fcbs_pkg::LEN_W-1:0]           len_sel, len_clamp;
    logic                                 d_we, c_we;
    logic [fcbs_pkg::MEM_AW-1:0]          d_waddr, c_waddr, d_raddr, c_raddr;
    logic signed [fcbs_pkg::SMP_W-1:0]    d_wdata, c_wdata;
    logic signed [fcbs_pkg::ACC_W-1:0]    acc_rnd;
    logic signed [fcbs_pkg::SUM_W-1:0]    sum_rnd;
    logic signed [fcbs_pkg::DIFF_W-1:0]   diff;
    logic signed [MIX_W-1:0]              p_tot, p_rnd;
    logic signed [TERM_W-1:0]             term;
    logic signed [Y_W-1:0]                y_full;
    logic signed [fcbs_pkg::SMP_W-1:0]    y_sat;
    logic [fcbs_pkg::FADE_W:0]            lv_sum;
    logic                                 fade_done;

    assign wp_cur   = r_wp[r_ch];
    assign wp_new   = wp_cur - 1'b1;
    assign staged   = ~r_active;
    assign bank_sel = r_active ^ i_cmd.pass_b;
    assign len_sel  = r_len[bank_sel];
    assign issue    = i_cmd.mac_run && (r_idx < len_sel);
    assign mac_clr  = i_cmd.samp_wr | i_cmd.save_a | i_cmd.save_b;
    assign tap_we   = i_cmd.tap_wr && !r_fading;
    assign len_clamp = (r_tap_len > fcbs_pkg::LEN_MAX) ? fcbs_pkg::LEN_MAX : r_tap_len;

    // memory port selection
    always_comb begin
        d_we    = i_cmd.sweep_init | i_cmd.sweep_clr | i_cmd.samp_wr;
        d_waddr = i_cmd.samp_wr ? {r_ch, wp_new} : r_sweep;
        d_wdata = i_cmd.samp_wr ? r_sample : '0;
        c_we    = i_cmd.sweep_init | tap_we;
        c_waddr = i_cmd.sweep_init ? r_sweep : {staged, r_tap_idx};
        if (i_cmd.sweep_init) begin
            c_wdata = (r_sweep[fcbs_pkg::TAP_AW-1:0] == '0) ? TAP_UNIT : '0;
        end else begin
            c_wdata = r_tap_val;
        end
        c_raddr = {bank_sel, r_idx[fcbs_pkg::TAP_AW-1:0]};
        d_raddr = {r_ch, wp_cur + r_idx[fcbs_pkg::TAP_AW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (d_we) dmem[d_waddr] <= d_wdata;
        if (c_we) cmem[c_waddr] <= c_wdata;
        r_dq <= dmem[d_raddr];
        r_cq <= cmem[c_raddr];
    end

    // rounding and crossfade arithmetic
    always_comb begin
        acc_rnd   = r_acc + ACC_HALF;
        sum_rnd   = fcbs_pkg::SUM_W'(acc_rnd >>> 20);
        diff      = fcbs_pkg::DIFF_W'(r_b) - fcbs_pkg::DIFF_W'(r_a);
        p_tot     = (MIX_W'(r_phi) <<< 20) + MIX_W'($signed({1'b0, r_plo}));
        p_rnd     = p_tot + MIX_HALF;
        term      = TERM_W'(p_rnd >>> 16);
        y_full    = Y_W'(r_a) + Y_W'(term);
        if (y_full > Y_MAX) begin
            y_sat = Y_MAX[fcbs_pkg::SMP_W-1:0];
        end else if (y_full < Y_MIN) begin
            y_sat = Y_MIN[fcbs_pkg::SMP_W-1:0];
        end else begin
            y_sat = y_full[fcbs_pkg::SMP_W-1:0];
        end
        lv_sum    = {1'b0, r_level} + {1'b0, r_step};
        fade_done = r_fading && r_level[fcbs_pkg::FADE_W-1];
    end

    // payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_in.operation;
            r_ch      <= i_in.channel;
            r_sample  <= i_in.sample_in;
            r_tap_idx <= i_in.tap_index;
            r_tap_val <= i_in.tap_value;
            r_tap_len <= i_in.tap_length;
        end
        r_prod <= r_cq * r_dq;
        if (mac_clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + fcbs_pkg::ACC_W'(r_prod);
        end
        if (i_cmd.save_a) begin
            r_a <= sum_rnd;
            r_b <= sum_rnd;
        end
        if (i_cmd.save_b) r_b <= sum_rnd;
        if (i_cmd.mix1) r_plo <= r_level * diff[19:0];
        if (i_cmd.mix2) r_phi <= $signed({1'b0, r_level}) * $signed(diff[fcbs_pkg::DIFF_W-1:20]);
        if (i_cmd.mix3) begin
            r_res.result_kind <= fcbs_pkg::KIND_SAMPLE;
            r_res.sample_out  <= y_sat;
            r_res.accepted    <= 1'b0;
            r_res.fading_now  <= r_fading && !fade_done;
        end else if (i_cmd.commit) begin
            r_res.result_kind <= fcbs_pkg::KIND_STATUS;
            r_res.sample_out  <= '0;
            r_res.accepted    <= !r_fading;
            r_res.fading_now  <= r_fading || (r_op == fcbs_pkg::OP_COMMIT);
        end
        if (i_cmd.emit) o_out <= r_res;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < fcbs_pkg::CHANNELS; c++) r_wp[c] <= '0;
            r_len[0]    <= fcbs_pkg::RESET_LEN;
            r_len[1]    <= fcbs_pkg::RESET_LEN;
            r_active    <= 1'b0;
            r_fading    <= 1'b0;
            r_level     <= '0;
            r_step      <= fcbs_pkg::RESET_STEP;
            r_sweep     <= '0;
            r_idx       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_step <= i_cfg_step;
            if (i_cmd.sweep_init || i_cmd.sweep_clr) begin
                r_sweep <= r_sweep + 1'b1;
                for (int c = 0; c < fcbs_pkg::CHANNELS; c++) r_wp[c] <= '0;
            end
            if (i_cmd.samp_wr) begin
                r_wp[r_ch] <= wp_new;
                if (r_fading && r_ch == '0) begin
                    r_level <= (lv_sum > {1'b0, fcbs_pkg::FADE_ONE}) ?
                               fcbs_pkg::FADE_ONE : lv_sum[fcbs_pkg::FADE_W-1:0];
                end
            end
            if (mac_clr) begin
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            r_v1 <= issue;
            r_v2 <= r_v1;
            // fade reaching one swaps banks at once
            if (i_cmd.mix3 && fade_done) begin
                r_active <= ~r_active;
                r_fading <= 1'b0;
                r_level  <= '0;
            end
            if (i_cmd.commit && !r_fading) begin
                r_len[staged] <= len_clamp;
                if (r_op == fcbs_pkg::OP_COMMIT) begin
                    r_fading <= 1'b1;
                    r_level  <= '0;
                end else begin
                    r_active <= staged;
                end
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_step = r_step;

    always_comb begin
        o_st.sweep_last = (r_sweep == fcbs_pkg::MEM_AW'(fcbs_pkg::MEM_DEPTH - 1));
        o_st.mac_done   = i_cmd.mac_run && !issue && !r_v1 && !r_v2;
        o_st.fading     = r_fading;
        o_st.out_free   = !o_out_valid || i_out_ready;
        o_st.commit_clr = (r_op == fcbs_pkg::OP_COMMIT_NOW) && !r_fading;
    end

endmodule

`default_nettype wire

@@ hw/rtl/fir_crossfade_bank_switch.sv @@
// ----------------------------------------------------------------------------
// fir_crossfade_bank_switch: two-bank multichannel fir with crossfade
// One shared multiply-accumulate walks the active bank (and the staged
// bank during a fade) over the channel history; the two sums are blended
// by the fade level and saturated to 24 bits.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  -------   ---------  ----------------------------  ------------------
//  in        input      i_in_valid / o_in_ready       i_in  (t_in_word)
//  out       output     o_out_valid / i_out_ready     o_out (t_out_word)
//  config    input      psel/penable/pwrite, pready   paddr/pwdata/prdata
//
//  a sample word is written into the history, then walks the active bank,
//  and the staged bank during a fade, one tap at a time through the single
//  mac and the one-read-per-cycle memories, then is blended and output;
//  a tap write goes straight back to idle, a commit also emits a status word
//  reset and clear-histories each run a sweep over the whole history
//  memory (reset also loads the unit impulse into both banks); no word is
//  taken during a sweep, config writes are taken at any time
//  the output register holds a result while the next word is taken; a
//  stalled output only holds the block when it has a new result to place
// ----------------------------------------------------------------------------
`default_nettype none

module fir_crossfade_bank_switch (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input words
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire fcbs_pkg::t_in_word              i_in,
    // result words
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output fcbs_pkg::t_out_word                  o_out,
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fcbs_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [fcbs_pkg::PDATA_W-1:0]    pwdata,
    output logic [fcbs_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    fcbs_pkg::t_cmd    cmd;
    fcbs_pkg::t_status st;
    logic              cfg_we;
    logic [fcbs_pkg::FADE_W-1:0] step;

    // register write lands in the access phase
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == fcbs_pkg::ADDR_FADE_STEP);
    assign prdata = (paddr == fcbs_pkg::ADDR_FADE_STEP) ?
                    fcbs_pkg::PDATA_W'(step) : '0;

    fcbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in.operation),
        .i_st       (st),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    fcbs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_step  (pwdata[fcbs_pkg::FADE_W-1:0]),
        .o_step      (step)
    );

endmodule

`default_nettype wire
